@@ hw/rtl/sprc_pkg.sv @@
// ----------------------------------------------------------------------------
// sprc_pkg
// Widths, pipeline depth and stage records for the sphere pair collision
// resolve datapath.
// ----------------------------------------------------------------------------
package sprc_pkg;

    localparam int NORM_BITS = 15;                 // normalized offset magnitude width
    localparam int QW        = 34;                 // projection quotient width
    localparam int DIV_STEP  = 2;                  // quotient bits per divider stage
    localparam int DIV_ST    = QW / DIV_STEP;      // divider stages
    localparam int FRONT_ST  = 9;                  // stages ahead of the divider
    localparam int NST       = FRONT_ST + DIV_ST + 1;

    // data that rides along the whole pipe
    typedef struct packed {
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
        logic             hit;
        logic             degen;
        logic             apply;
        logic [2:0]       oneg;
    } side_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][31:0] om;
        logic [2:0][32:0] rel;
        logic [30:0]      r;
    } s1_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][31:0] om;
        logic [2:0][32:0] rel;
        logic [2:0][63:0] sq;
        logic [61:0]      r2;
        logic [31:0]      mx;
    } s2_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][31:0] om;
        logic [2:0][32:0] rel;
        logic [5:0]       b;
    } s3_t;

    typedef struct packed {
        side_t                      sd;
        logic [2:0][32:0]           rel;
        logic [2:0][NORM_BITS-1:0]  m;
    } s4_t;

    typedef struct packed {
        side_t                          sd;
        logic [2:0][48:0]               prod;
        logic [2:0][2*NORM_BITS-1:0]    msq;
        logic [2:0][NORM_BITS-1:0]      m;
    } s5_t;

    typedef struct packed {
        side_t                      sd;
        logic [2:0][NORM_BITS-1:0]  m;
        logic [50:0]                dot;
        logic [31:0]                n;
    } s6_t;

    typedef struct packed {
        side_t                      sd;
        logic [2:0][NORM_BITS-1:0]  m;
        logic                       dneg;
        logic [48:0]                dm;
        logic [31:0]                n;
    } s7_t;

    typedef struct packed {
        side_t            sd;
        logic             dneg;
        logic [31:0]      n;
        logic [2:0][63:0] num;
    } s8_t;

    typedef struct packed {
        side_t              sd;
        logic               dneg;
        logic [31:0]        n;
        logic [2:0][31:0]   rem;
        logic [2:0][QW-1:0] low;
        logic [2:0][QW-1:0] q;
    } dv_t;

    typedef struct packed {
        logic             hit;
        logic             degen;
        logic [2:0][31:0] nf;
        logic [2:0][31:0] ns;
    } res_t;

endpackage

@@ hw/rtl/sphere_pair_collision_resolve_unit.sv @@
// ----------------------------------------------------------------------------
// sphere_pair_collision_resolve_unit
// Equal-mass elastic collision of two spheres, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall) carries one sphere pair: center
// offset, radius sum and both velocities, Q16.16. Output channel
// (result_valid / result_stall) returns hit, degenerate and both new
// velocities, saturated to 32 bits, one result per pair, in order.
// The pipe has 27 register stages: nine front stages (abs/relative
// velocity, squares, hit test and leading-one, normalize, products, sums,
// abs of dot, dot times offset, rounding add), a 17-stage restoring
// divider resolving two quotient bits per stage in three lanes, and the
// output stage that applies the projection and saturates.
// Throughput is one pair per cycle while the receiver does not stall. Every
// stage carries its own valid bit and loads when it is empty or when the
// stage behind it moves, so bubbles are squeezed out while the receiver
// stalls and the input keeps taking transfers until the pipe is full. Reset
// clears all valid bits; the block needs no setup after reset.
// ----------------------------------------------------------------------------
module sphere_pair_collision_resolve_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] offset_x,
    input  logic [31:0] offset_y,
    input  logic [31:0] offset_z,
    input  logic [30:0] radius_sum,
    input  logic [31:0] first_vel_x,
    input  logic [31:0] first_vel_y,
    input  logic [31:0] first_vel_z,
    input  logic [31:0] second_vel_x,
    input  logic [31:0] second_vel_y,
    input  logic [31:0] second_vel_z,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        hit,
    output logic        degenerate,
    output logic [31:0] new_first_x,
    output logic [31:0] new_first_y,
    output logic [31:0] new_first_z,
    output logic [31:0] new_second_x,
    output logic [31:0] new_second_y,
    output logic [31:0] new_second_z
);
    import sprc_pkg::*;

    function automatic dv_t div_step(input dv_t d);
        dv_t        r;
        logic [32:0] t;
        r = d;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < DIV_STEP; k++)
            begin
                t = {r.rem[i], r.low[i][QW-1]};
                r.low[i] = {r.low[i][QW-2:0], 1'b0};
                if (t >= {1'b0, r.n})
                begin
                    r.rem[i] = 32'(t - {1'b0, r.n});
                    r.q[i]   = {r.q[i][QW-2:0], 1'b1};
                end
                else
                begin
                    r.rem[i] = t[31:0];
                    r.q[i]   = {r.q[i][QW-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (v < -36'sh0_8000_0000)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ld;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;
    s7_t  s7_reg, s7_next;
    s8_t  s8_reg, s8_next;
    dv_t  s9_reg, s9_next;
    dv_t  dv_reg  [DIV_ST];
    dv_t  dv_next [DIV_ST];
    res_t res_reg, res_next;

    // ---------------- handshake: a stage loads when empty or draining
    always_comb
    begin
        ld[NST-1] = !vld_reg[NST-1] || !result_stall;
        for (int s = NST - 2; s >= 0; s--)
            ld[s] = !vld_reg[s] || ld[s+1];
    end

    assign item_stall   = !ld[0];
    assign result_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ld[0])
                vld_reg[0] <= item_valid;
            for (int s = 1; s < NST; s++)
                if (ld[s])
                    vld_reg[s] <= vld_reg[s-1];
        end
    end

    // ---------------- stage 1: magnitudes, relative velocity
    always_comb
    begin
        logic [2:0][31:0] o;
        o = {offset_z, offset_y, offset_x};
        s1_next = '0;
        s1_next.sd.v1 = {first_vel_z, first_vel_y, first_vel_x};
        s1_next.sd.v2 = {second_vel_z, second_vel_y, second_vel_x};
        s1_next.r     = radius_sum;
        for (int i = 0; i < 3; i++)
        begin
            s1_next.sd.oneg[i] = o[i][31];
            s1_next.om[i]  = o[i][31] ? 32'(-o[i]) : o[i];
            s1_next.rel[i] = 33'($signed({s1_next.sd.v1[i][31], s1_next.sd.v1[i]})
                                 - $signed({s1_next.sd.v2[i][31], s1_next.sd.v2[i]}));
        end
        s1_next.sd.degen = (o == '0);
    end

    // ---------------- stage 2: squares, largest magnitude
    always_comb
    begin
        s2_next     = '0;
        s2_next.sd  = s1_reg.sd;
        s2_next.om  = s1_reg.om;
        s2_next.rel = s1_reg.rel;
        for (int i = 0; i < 3; i++)
            s2_next.sq[i] = 64'(s1_reg.om[i]) * 64'(s1_reg.om[i]);
        s2_next.r2 = 62'(s1_reg.r) * 62'(s1_reg.r);
        s2_next.mx = s1_reg.om[0];
        if (s1_reg.om[1] > s2_next.mx)
            s2_next.mx = s1_reg.om[1];
        if (s1_reg.om[2] > s2_next.mx)
            s2_next.mx = s1_reg.om[2];
    end

    // ---------------- stage 3: hit test, leading one of largest magnitude
    always_comb
    begin
        logic [63:0] len2;
        s3_next     = '0;
        s3_next.sd  = s2_reg.sd;
        s3_next.om  = s2_reg.om;
        s3_next.rel = s2_reg.rel;
        len2 = s2_reg.sq[0] + s2_reg.sq[1] + s2_reg.sq[2];
        s3_next.sd.hit   = (len2 <= {2'b00, s2_reg.r2});
        s3_next.sd.apply = s3_next.sd.hit && !s2_reg.sd.degen;
        s3_next.b = '0;
        for (int k = 0; k < 32; k++)
            if (s2_reg.mx[k])
                s3_next.b = 6'(k + 1);
    end

    // ---------------- stage 4: normalize offset so its largest magnitude lies in [2^14, 2^15)
    always_comb
    begin
        logic [31:0] sh;
        s4_next     = '0;
        s4_next.sd  = s3_reg.sd;
        s4_next.rel = s3_reg.rel;
        for (int i = 0; i < 3; i++)
        begin
            if (s3_reg.b > 6'(NORM_BITS))
                sh = s3_reg.om[i] >> (s3_reg.b - 6'(NORM_BITS));
            else
                sh = s3_reg.om[i] << (6'(NORM_BITS) - s3_reg.b);
            s4_next.m[i] = sh[NORM_BITS-1:0];
        end
    end

    // ---------------- stage 5: dot products per lane, squared norm terms
    always_comb
    begin
        logic signed [NORM_BITS:0] on;
        logic signed [48:0]        pr;
        s5_next    = '0;
        s5_next.sd = s4_reg.sd;
        s5_next.m  = s4_reg.m;
        for (int i = 0; i < 3; i++)
        begin
            on = s4_reg.sd.oneg[i] ? -$signed({1'b0, s4_reg.m[i]})
                                   :  $signed({1'b0, s4_reg.m[i]});
            pr = $signed(s4_reg.rel[i]) * on;
            s5_next.prod[i] = pr;
            s5_next.msq[i]  = (2*NORM_BITS)'(s4_reg.m[i]) * (2*NORM_BITS)'(s4_reg.m[i]);
        end
    end

    // ---------------- stage 6: sums
    always_comb
    begin
        s6_next    = '0;
        s6_next.sd = s5_reg.sd;
        s6_next.m  = s5_reg.m;
        s6_next.dot = 51'($signed(s5_reg.prod[0])) + 51'($signed(s5_reg.prod[1]))
                    + 51'($signed(s5_reg.prod[2]));
        s6_next.n = 32'(s5_reg.msq[0]) + 32'(s5_reg.msq[1]) + 32'(s5_reg.msq[2]);
    end

    // ---------------- stage 7: magnitude of dot
    always_comb
    begin
        logic [50:0] a;
        s7_next      = '0;
        s7_next.sd   = s6_reg.sd;
        s7_next.m    = s6_reg.m;
        s7_next.n    = s6_reg.n;
        s7_next.dneg = s6_reg.dot[50];
        a = s6_reg.dot[50] ? 51'(-s6_reg.dot) : s6_reg.dot;
        s7_next.dm = a[48:0];
    end

    // ---------------- stage 8: |dot| * |o|
    always_comb
    begin
        s8_next      = '0;
        s8_next.sd   = s7_reg.sd;
        s8_next.dneg = s7_reg.dneg;
        s8_next.n    = s7_reg.n;
        for (int i = 0; i < 3; i++)
            s8_next.num[i] = 64'(s7_reg.dm) * 64'(s7_reg.m[i]);
    end

    // ---------------- stage 9: round to nearest, load divider
    always_comb
    begin
        logic [63:0] nr;
        s9_next      = '0;
        s9_next.sd   = s8_reg.sd;
        s9_next.dneg = s8_reg.dneg;
        s9_next.n    = s8_reg.n;
        for (int i = 0; i < 3; i++)
        begin
            nr = s8_reg.num[i] + 64'(s8_reg.n >> 1);
            s9_next.rem[i] = 32'(nr[63:QW]);
            s9_next.low[i] = nr[QW-1:0];
            s9_next.q[i]   = '0;
        end
    end

    // ---------------- divider stages
    always_comb
    begin
        dv_next[0] = div_step(s9_reg);
        for (int k = 1; k < DIV_ST; k++)
            dv_next[k] = div_step(dv_reg[k-1]);
    end

    // ---------------- output stage: apply projection, saturate
    always_comb
    begin
        dv_t                d;
        logic signed [35:0] ps;
        d = dv_reg[DIV_ST-1];
        res_next       = '0;
        res_next.hit   = d.sd.hit;
        res_next.degen = d.sd.degen;
        for (int i = 0; i < 3; i++)
        begin
            ps = $signed({2'b00, d.q[i]});
            if (d.dneg ^ d.sd.oneg[i])
                ps = -ps;
            if (!d.sd.apply)
                ps = '0;
            res_next.nf[i] = sat32(36'($signed(d.sd.v1[i])) - ps);
            res_next.ns[i] = sat32(36'($signed(d.sd.v2[i])) + ps);
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        if (ld[0]) s1_reg <= s1_next;
        if (ld[1]) s2_reg <= s2_next;
        if (ld[2]) s3_reg <= s3_next;
        if (ld[3]) s4_reg <= s4_next;
        if (ld[4]) s5_reg <= s5_next;
        if (ld[5]) s6_reg <= s6_next;
        if (ld[6]) s7_reg <= s7_next;
        if (ld[7]) s8_reg <= s8_next;
        if (ld[8]) s9_reg <= s9_next;
        for (int k = 0; k < DIV_ST; k++)
            if (ld[FRONT_ST+k])
                dv_reg[k] <= dv_next[k];
        if (ld[NST-1]) res_reg <= res_next;
    end

    assign hit          = res_reg.hit;
    assign degenerate   = res_reg.degen;
    assign new_first_x  = res_reg.nf[0];
    assign new_first_y  = res_reg.nf[1];
    assign new_first_z  = res_reg.nf[2];
    assign new_second_x = res_reg.ns[0];
    assign new_second_y = res_reg.ns[1];
    assign new_second_z = res_reg.ns[2];

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere pair collision resolve unit: a queue
// fed driver, a result monitor with random stall, and a bit-exact predictor
// of the fixed-point projection compared field by field in transfer order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import sprc_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] off;
        logic [30:0]      r;
        logic [2:0][31:0] v1;
        logic [2:0][31:0] v2;
    } pair_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic [31:0] offset_x, offset_y, offset_z;
    logic [30:0] radius_sum;
    logic [31:0] first_vel_x, first_vel_y, first_vel_z;
    logic [31:0] second_vel_x, second_vel_y, second_vel_z;
    logic result_valid;
    logic result_stall;
    logic hit, degenerate;
    logic [31:0] new_first_x, new_first_y, new_first_z;
    logic [31:0] new_second_x, new_second_y, new_second_z;

    pair_t pending_pairs[$];
    res_t  expected_results[$];
    int    sent_count;
    int    mismatch_count;

    sphere_pair_collision_resolve_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
        .radius_sum(radius_sum),
        .first_vel_x(first_vel_x), .first_vel_y(first_vel_y), .first_vel_z(first_vel_z),
        .second_vel_x(second_vel_x), .second_vel_y(second_vel_y),
        .second_vel_z(second_vel_z),
        .result_valid(result_valid), .result_stall(result_stall),
        .hit(hit), .degenerate(degenerate),
        .new_first_x(new_first_x), .new_first_y(new_first_y), .new_first_z(new_first_z),
        .new_second_x(new_second_x), .new_second_y(new_second_y),
        .new_second_z(new_second_z)
    );

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] mag(longint v);
        logic [63:0] u;
        u = v;
        return v < 0 ? -u : u;
    endfunction

    function automatic res_t resolve_collision(pair_t t);
        longint o[3], v1[3], v2[3], p[3], on[3], dot;
        logic [63:0] om[3], len2, r, mx, n, dm, m, q, tmp;
        int b;
        bit neg;
        res_t rs;
        len2 = 0;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            o[i] = longint'($signed(t.off[i]));
            v1[i] = longint'($signed(t.v1[i]));
            v2[i] = longint'($signed(t.v2[i]));
            om[i] = mag(o[i]);
            len2 += om[i] * om[i];
            if (om[i] > mx)
                mx = om[i];
            p[i] = 0;
        end
        r = {33'd0, t.r};
        rs.hit = (len2 <= r * r);
        rs.degen = (mx == 0);
        if (rs.hit && !rs.degen)
        begin
            b = 0;
            tmp = mx;
            while (tmp != 0)
            begin
                tmp >>= 1;
                b++;
            end
            n = 0;
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (b > NORM_BITS)
                    m = om[i] >> (b - NORM_BITS);
                else
                    m = om[i] << (NORM_BITS - b);
                n += m * m;
                on[i] = o[i] < 0 ? -longint'(m) : longint'(m);
                dot += (v1[i] - v2[i]) * on[i];
            end
            dm = mag(dot);
            for (int i = 0; i < 3; i++)
            begin
                // numerator stays below 2^64 for any input
                q = (dm * mag(on[i]) + n / 2) / n;
                neg = (dot < 0) != (on[i] < 0);
                p[i] = neg ? -longint'(q) : longint'(q);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            rs.nf[i] = sat32(v1[i] - p[i]);
            rs.ns[i] = sat32(v2[i] + p[i]);
        end
        return rs;
    endfunction

    function automatic pair_t make_pair(int ox, int oy, int oz, int r,
                                        int ax, int ay, int az, int bx, int by, int bz);
        pair_t t;
        t.off[0] = ox; t.off[1] = oy; t.off[2] = oz;
        t.r = 31'(r);
        t.v1[0] = ax; t.v1[1] = ay; t.v1[2] = az;
        t.v2[0] = bx; t.v2[1] = by; t.v2[2] = bz;
        return t;
    endfunction

    task automatic queue_pair(pair_t t);
        pending_pairs = {pending_pairs, t};
    endtask

    function automatic logic [31:0] scaled_rand();
        return $signed($urandom()) >>> $urandom_range(0, 31);
    endfunction

    function automatic pair_t random_pair();
        pair_t t;
        int kind;
        int sh;
        kind = $urandom_range(0, 99);
        sh = $urandom_range(0, 31);
        for (int i = 0; i < 3; i++)
        begin
            t.off[i] = $signed($urandom()) >>> sh;
            t.v1[i] = scaled_rand();
            t.v2[i] = scaled_rand();
        end
        if (kind < 15)
        begin
            // full-range noise, mostly misses
            for (int i = 0; i < 3; i++)
            begin
                t.off[i] = $urandom();
                t.v1[i] = $urandom();
                t.v2[i] = $urandom();
            end
            t.r = 31'($urandom());
        end
        else if (kind < 60)
            t.r = 31'h7fffffff >> $urandom_range(0, 2);
        else
            t.r = 31'($urandom() >> $urandom_range(1, 31));
        if (kind >= 80 && kind < 88)
        begin
            // head-on: relative velocity along the offset
            for (int i = 0; i < 3; i++)
            begin
                t.v2[i] = scaled_rand() >>> 1;
                t.v1[i] = t.v2[i] + ($signed(t.off[i]) >>> 1);
            end
        end
        else if (kind >= 88 && kind < 92)
            t.v1 = t.v2;
        else if (kind >= 92 && kind < 94)
            t.off = '0;
        return t;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    // driver: queues the prediction on each input transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_results = {expected_results, resolve_collision(
                    {offset_z, offset_y, offset_x, radius_sum,
                     first_vel_z, first_vel_y, first_vel_x,
                     second_vel_z, second_vel_y, second_vel_x})};
                sent_count++;
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_pairs.size() != 0 &&
                    ((sent_count > 150 && sent_count < 300) || $urandom_range(0, 99) >= 15))
                begin
                    pair_t t;
                    t = pending_pairs.pop_front();
                    item_valid <= 1'b1;
                    {offset_z, offset_y, offset_x} <= t.off;
                    radius_sum <= t.r;
                    {first_vel_z, first_vel_y, first_vel_x} <= t.v1;
                    {second_vel_z, second_vel_y, second_vel_x} <= t.v2;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: random receiver stall, in-order compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer at %0t", $realtime);
                end
                else
                begin
                    res_t e;
                    res_t a;
                    e = expected_results.pop_front();
                    a.hit = hit;
                    a.degen = degenerate;
                    a.nf = {new_first_z, new_first_y, new_first_x};
                    a.ns = {new_second_z, new_second_y, new_second_x};
                    if (a.hit !== e.hit || a.degen !== e.degen ||
                        a.nf !== e.nf || a.ns !== e.ns)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp hit=%0b deg=%0b nf=%h ns=%h,",
                                      " got hit=%0b deg=%0b nf=%h ns=%h"},
                                     e.hit, e.degen, e.nf, e.ns,
                                     a.hit, a.degen, a.nf, a.ns);
                    end
                end
            end
            result_stall <= (sent_count > 150 && sent_count < 300) ? 1'b0
                            : ($urandom_range(0, 99) < 15);
        end
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        item_valid = 1'b0;
        result_stall = 1'b0;
        offset_x = '0; offset_y = '0; offset_z = '0; radius_sum = '0;
        first_vel_x = '0; first_vel_y = '0; first_vel_z = '0;
        second_vel_x = '0; second_vel_y = '0; second_vel_z = '0;
        sent_count = 0;
        mismatch_count = 0;

        // zero offset, always a hit even with zero radius
        queue_pair(make_pair(0, 0, 0, 0, 5, -7, 9, 1, 2, 3));
        // miss
        queue_pair(make_pair(32'h00030000, 0, 0, 32'h00010000,
                             100, 200, 300, -4, -5, -6));
        // touching exactly
        queue_pair(make_pair(32'h00020000, 0, 0, 32'h00020000,
                             32'h00010000, 0, 0, 0, 0, 0));
        // head-on
        queue_pair(make_pair(3, 4, 0, 5, 30, 40, 0, 0, 0, 0));
        // zero relative velocity
        queue_pair(make_pair(1, -1, 1, 100, 77, 77, 77, 77, 77, 77));
        // extreme offsets and radius
        queue_pair(make_pair(32'h80000000, 0, 0, 31'h7fffffff,
                             32'h7fffffff, 0, 0, 32'h80000000, 0, 0));
        queue_pair(make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                             31'h7fffffff, 32'h80000000, 32'h7fffffff,
                             32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff));
        queue_pair(make_pair(-1, -1, -1, 31'h7fffffff,
                             32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        queue_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                             31'h7fffffff, 1, 2, 3, 4, 5, 6));
        queue_pair(make_pair(1, 0, 0, 1, 32'h7fffffff, -1, 0,
                             32'h80000000, 0, 1));
        queue_pair(make_pair(0, 0, -1, 1, 0, 0, 32'h80000000,
                             0, 0, 32'h7fffffff));
        queue_pair(make_pair(32'hffffffff, 32'hffffffff, 32'hffffffff,
                             0, -1, -1, -1, -1, -1, -1));
        queue_pair(make_pair(32'h00004000, 32'h00007fff, 32'hffff8000,
                             31'h7fffffff, 32'h12345678, 32'h9abcdef0,
                             32'h0fedcba9, 32'h87654321, 32'h55555555,
                             32'haaaaaaaa));
        for (int k = 0; k < 450; k++)
            queue_pair(random_pair());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (item_valid)
            @(posedge clk);
        guard = 0;
        while (expected_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_results.size() != 0)
            mismatch_count++;
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
